[sv/mkfs_pkg.sv]
// ----------------------------------------------------------------------------
// mkfs_pkg
// Shared types, codes and helpers for the multi-key flow scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mkfs_pkg;

  // Default number of wait queue slots.
  localparam int unsigned QueueDepth = 16;

  // Width of a packed sort key: {priority, arrival, transmit, id}.
  localparam int unsigned KeyW = 48;

  typedef logic [KeyW-1:0] key_t;

  // Operation carried by an input item.
  typedef enum logic [0:0] {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_HEAD    = 3'd3,
    ST_IDLE    = 3'd4,
    ST_IGNORED = 3'd5
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  flow_id;
    logic [7:0]  flow_priority;
    logic [15:0] arrival_tenths;
    logic [15:0] transmit_tenths;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] granted_id;
    logic [7:0] holder_id;
    logic [4:0] waiting_count;
  } out_item_t;

  // Per-cycle command broadcast to every queue cell.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

  // Pack the ordering key so an unsigned compare gives the queue order.
  function automatic key_t make_key(in_item_t item);
    return {item.flow_priority, item.arrival_tenths, item.transmit_tenths, item.flow_id};
  endfunction

endpackage

`default_nettype wire

[sv/multi_key_flow_scheduler.sv]
// ----------------------------------------------------------------------------
// multi_key_flow_scheduler
// Non-preemptive single-channel scheduler with a sorted wait queue built as a
// row of shifting compare cells.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; every cell compares and
// shifts in parallel. An item enters in the same cycle as the previous result
// is taken; while a result is held back by the receiver, the input stalls.
// Reset clears the queue count, the channel holder and the output valid flag;
// queue slots hold unknown keys until written and are never read before then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_key_flow_scheduler #(
  parameter int unsigned QUEUE_DEPTH = mkfs_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire mkfs_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mkfs_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic [7:0]          holder_q, holder_d;
  logic                out_valid_q, out_valid_d;
  mkfs_pkg::out_item_t out_q, out_d;

  logic                 accept;
  logic                 is_request;
  logic                 grant_now;
  logic                 queue_full;
  mkfs_pkg::cell_ctrl_t ctrl;
  mkfs_pkg::key_t       new_key;
  mkfs_pkg::key_t       cell_key [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_shift;
  logic [QUEUE_DEPTH-1:0] occupied;

  // Input handshake: stall only while a result is held back downstream.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Decode the item.
  assign is_request = (in_item_i.opcode == mkfs_pkg::OP_REQUEST);
  assign grant_now  = is_request && (holder_q == 8'd0) && (count_q == '0);
  assign queue_full = (count_q == CntW'(QUEUE_DEPTH));
  assign new_key    = mkfs_pkg::make_key(in_item_i);

  assign ctrl.insert = accept && is_request && !grant_now && !queue_full;
  assign ctrl.pop    = accept && !is_request && (count_q != '0);

  // Row of queue cells, head at index zero.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic           left_shift;
    mkfs_pkg::key_t left_key;
    mkfs_pkg::key_t right_key;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_shift = 1'b0;
      assign left_key   = new_key;
    end else begin : g_body
      assign left_shift = cell_shift[i-1];
      assign left_key   = cell_key[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    mkfs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key),
      .occupied_i   (occupied[i]),
      .left_shift_i (left_shift),
      .left_key_i   (left_key),
      .right_key_i  (right_key),
      .shift_o      (cell_shift[i]),
      .key_o        (cell_key[i])
    );
  end

  // Channel state and result for the accepted item.
  always_comb begin
    count_d           = count_q;
    holder_d          = holder_q;
    out_d.status      = mkfs_pkg::ST_IGNORED;
    out_d.granted_id  = 8'd0;
    if (is_request) begin
      if (grant_now) begin
        holder_d         = in_item_i.flow_id;
        out_d.status     = mkfs_pkg::ST_GRANTED;
        out_d.granted_id = in_item_i.flow_id;
      end else if (queue_full) begin
        out_d.status = mkfs_pkg::ST_DROPPED;
      end else begin
        count_d      = count_q + 1'b1;
        out_d.status = mkfs_pkg::ST_QUEUED;
      end
    end else if (count_q != '0) begin
      count_d          = count_q - 1'b1;
      holder_d         = cell_key[0][7:0];
      out_d.status     = mkfs_pkg::ST_HEAD;
      out_d.granted_id = cell_key[0][7:0];
    end else if (holder_q != 8'd0) begin
      holder_d     = 8'd0;
      out_d.status = mkfs_pkg::ST_IDLE;
    end
    out_d.holder_id     = holder_d;
    out_d.waiting_count = 5'(count_d);
  end

  // Output valid: set on accept, held while stalled.
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      holder_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q  <= count_d;
        holder_q <= holder_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Assertions.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("wait queue count exceeds depth");

  a_valid_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result appeared without an accepted item");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the queue by one");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not shrink the queue by one");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.insert && ctrl.pop))
    else $error("insert and pop in the same cycle");

endmodule

`default_nettype wire

[sv/mkfs_cell.sv]
// ----------------------------------------------------------------------------
// mkfs_cell
// One slot of the sorted wait queue. Holds one key, compares it with the
// incoming key and shifts toward its neighbors on insert or pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mkfs_cell (
  input  wire logic                clk_i,
  input  wire mkfs_pkg::cell_ctrl_t ctrl_i,
  input  wire mkfs_pkg::key_t      new_key_i,
  input  wire logic                occupied_i,
  input  wire logic                left_shift_i,
  input  wire mkfs_pkg::key_t      left_key_i,
  input  wire mkfs_pkg::key_t      right_key_i,
  output logic                     shift_o,
  output mkfs_pkg::key_t           key_o
);

  mkfs_pkg::key_t key_q;
  mkfs_pkg::key_t key_d;
  logic           greater;

  // An occupied slot whose key sorts after the new one moves right on insert.
  assign greater = occupied_i && (key_q > new_key_i);
  assign shift_o = greater;

  // Next key: shift in from the left, take the new key, or pull from the right.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.insert) begin
      if (left_shift_i) begin
        key_d = left_key_i;
      end else if (greater || !occupied_i) begin
        key_d = new_key_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

`default_nettype wire
